FILE: rtl/rlq_pkg.sv
// ----------------------------------------------------------------------------
// rlq_pkg
// Shared types and constants of the four-level ready queue.
// ----------------------------------------------------------------------------
package rlq_pkg;

  localparam int LEVEL_DEPTH = 16;
  localparam int INDEX_BITS  = 8;
  localparam int NUM_LEVELS  = 4;

  localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
  localparam int TOTAL_W = $clog2(NUM_LEVELS * LEVEL_DEPTH + 1);
  localparam int LVL_W   = 2;
  localparam int PIDX_W  = 8;
  localparam int HEAD_W  = 8;
  localparam int TCNT_W  = 7;
  localparam int STAT_W  = 2;

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_PUSH_FULL = 2'd1,
    ST_POP_EMPTY = 2'd2
  } status_t;

  // Per-cell control: shift toward the head, or load the pushed index.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  // Per-level control from the top level.
  typedef struct packed {
    logic push;
    logic pop;
  } lvl_ctrl_t;

endpackage

FILE: rtl/four_level_ready_queue_unit.sv
// ----------------------------------------------------------------------------
// four_level_ready_queue_unit
// Strict-priority ready queue: four FIFO levels of process indices.
//
//   channel | direction | fields
//   --------+-----------+---------------------------------------------------
//   in_     | input     | operation, process_index, priority_level
//   out_    | output    | head_index, head_valid, total_count, status
//
// One operation per cycle while in_stall is low: each level is a shifting chain
// of cells, so a push loads one cell and a pop shifts the chain in the same edge;
// the result is picked from the next state and loaded into the output register
// at that edge. Reset clears the level counts; cell contents need no clearing.
// in_stall rises only while a result is held and out_stall is high.
// ----------------------------------------------------------------------------
module four_level_ready_queue_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_operation,
  input  logic [rlq_pkg::PIDX_W-1:0] in_process_index,
  input  logic [rlq_pkg::LVL_W-1:0]  in_priority_level,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rlq_pkg::HEAD_W-1:0] out_head_index,
  output logic                       out_head_valid,
  output logic [rlq_pkg::TCNT_W-1:0] out_total_count,
  output logic [rlq_pkg::STAT_W-1:0] out_status
);

  localparam int NL = rlq_pkg::NUM_LEVELS;

  logic               accept;
  rlq_pkg::index_t    push_idx;
  rlq_pkg::lvl_ctrl_t lvl_ctrl  [NL];
  rlq_pkg::cnt_t      cnt_r     [NL];
  rlq_pkg::cnt_t      cnt_nxt   [NL];
  rlq_pkg::index_t    head_nxt  [NL];

  logic [rlq_pkg::LVL_W-1:0] top_cur;
  logic                      any_cur;
  logic [rlq_pkg::LVL_W-1:0] top_nxt;
  logic                      any_nxt;
  logic                      push_ok;
  rlq_pkg::status_t          status_c;
  rlq_pkg::index_t           head_c;
  logic [rlq_pkg::TOTAL_W-1:0] total_c;

  logic [rlq_pkg::PIDX_W+rlq_pkg::INDEX_BITS-1:0] idx_ext;
  logic [rlq_pkg::HEAD_W+rlq_pkg::INDEX_BITS-1:0] head_ext;
  logic [rlq_pkg::TCNT_W+rlq_pkg::TOTAL_W-1:0]    total_ext;

  logic                       out_valid_r, out_valid_nxt;
  logic [rlq_pkg::HEAD_W-1:0] head_r;
  logic                       hvalid_r;
  logic [rlq_pkg::TCNT_W-1:0] total_r;
  logic [rlq_pkg::STAT_W-1:0] status_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign idx_ext  = {{rlq_pkg::PIDX_W{1'b0}}, in_process_index};
  assign push_idx = idx_ext[rlq_pkg::INDEX_BITS-1:0];

  // Lowest-numbered (highest-priority) non-empty level before the operation.
  always_comb begin
    top_cur = '0;
    any_cur = 1'b0;
    for (int l = NL - 1; l >= 0; l--) begin
      if (cnt_r[l] != '0) begin
        top_cur = rlq_pkg::LVL_W'(l);
        any_cur = 1'b1;
      end
    end
  end

  assign push_ok = (cnt_r[in_priority_level] != rlq_pkg::CNT_W'(rlq_pkg::LEVEL_DEPTH));

  always_comb begin
    status_c = rlq_pkg::ST_DONE;
    if (in_operation == rlq_pkg::OP_PUSH) begin
      if (!push_ok) status_c = rlq_pkg::ST_PUSH_FULL;
    end else begin
      if (!any_cur) status_c = rlq_pkg::ST_POP_EMPTY;
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      lvl_ctrl[l].push = accept && (in_operation == rlq_pkg::OP_PUSH) && push_ok &&
                         (in_priority_level == rlq_pkg::LVL_W'(l));
      lvl_ctrl[l].pop  = accept && (in_operation == rlq_pkg::OP_POP) && any_cur &&
                         (top_cur == rlq_pkg::LVL_W'(l));
    end
  end

  genvar gl;
  generate
    for (gl = 0; gl < NL; gl++) begin : g_level
      rlq_level u_level (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lvl_ctrl[gl]),
        .push_data (push_idx),
        .count_r   (cnt_r[gl]),
        .count_nxt (cnt_nxt[gl]),
        .head_nxt  (head_nxt[gl])
      );
    end
  endgenerate

  // Pick the result from the state after the operation.
  always_comb begin
    top_nxt = '0;
    any_nxt = 1'b0;
    total_c = '0;
    for (int l = NL - 1; l >= 0; l--) begin
      if (cnt_nxt[l] != '0) begin
        top_nxt = rlq_pkg::LVL_W'(l);
        any_nxt = 1'b1;
      end
    end
    for (int l = 0; l < NL; l++) begin
      total_c = total_c + rlq_pkg::TOTAL_W'(cnt_nxt[l]);
    end
  end

  assign head_c    = any_nxt ? head_nxt[top_nxt] : '0;
  assign head_ext  = {{rlq_pkg::HEAD_W{1'b0}}, head_c};
  assign total_ext = {{rlq_pkg::TCNT_W{1'b0}}, total_c};

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_r   <= head_ext[rlq_pkg::HEAD_W-1:0];
      hvalid_r <= any_nxt;
      total_r  <= total_ext[rlq_pkg::TCNT_W-1:0];
      status_r <= status_c;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_head_index  = head_r;
  assign out_head_valid  = hvalid_r;
  assign out_total_count = total_r;
  assign out_status      = status_r;

endmodule

FILE: rtl/rlq_cell.sv
// ----------------------------------------------------------------------------
// rlq_cell
// One FIFO slot: takes the neighbor's entry on a pop, or the pushed index.
// ----------------------------------------------------------------------------
module rlq_cell (
  input  logic                clk,
  input  rlq_pkg::cell_ctrl_t ctrl,
  input  rlq_pkg::index_t     load_data,
  input  rlq_pkg::index_t     next_data,
  output rlq_pkg::index_t     data_nxt,
  output rlq_pkg::index_t     data_r
);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift) begin
      data_nxt = next_data;
    end else if (ctrl.load) begin
      data_nxt = load_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

FILE: rtl/rlq_level.sv
// ----------------------------------------------------------------------------
// rlq_level
// One priority level: a chain of cells with the head in cell 0, plus its count.
// ----------------------------------------------------------------------------
module rlq_level (
  input  logic               clk,
  input  logic               rst_n,
  input  rlq_pkg::lvl_ctrl_t ctrl,
  input  rlq_pkg::index_t    push_data,
  output rlq_pkg::cnt_t      count_r,
  output rlq_pkg::cnt_t      count_nxt,
  output rlq_pkg::index_t    head_nxt
);

  rlq_pkg::index_t    cell_data [rlq_pkg::LEVEL_DEPTH];
  rlq_pkg::index_t    cell_nxt  [rlq_pkg::LEVEL_DEPTH];
  rlq_pkg::cell_ctrl_t cell_ctrl [rlq_pkg::LEVEL_DEPTH];

  genvar gi;
  generate
    for (gi = 0; gi < rlq_pkg::LEVEL_DEPTH; gi++) begin : g_cell
      rlq_pkg::index_t nb_data;

      if (gi == rlq_pkg::LEVEL_DEPTH - 1) begin : g_last
        assign nb_data = cell_data[gi];
      end else begin : g_mid
        assign nb_data = cell_data[gi+1];
      end

      assign cell_ctrl[gi].shift = ctrl.pop;
      assign cell_ctrl[gi].load  = ctrl.push && (count_r == rlq_pkg::CNT_W'(gi));

      rlq_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl[gi]),
        .load_data (push_data),
        .next_data (nb_data),
        .data_nxt  (cell_nxt[gi]),
        .data_r    (cell_data[gi])
      );
    end
  endgenerate

  assign head_nxt = cell_nxt[0];

  always_comb begin
    count_nxt = count_r;
    if (ctrl.push) begin
      count_nxt = count_r + rlq_pkg::CNT_W'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - rlq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

FILE: rtl/rlq_checker.sv
// ----------------------------------------------------------------------------
// rlq_checker
// Port-level checks of the ready queue, bound to the top level.
// ----------------------------------------------------------------------------
module rlq_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [rlq_pkg::HEAD_W-1:0] out_head_index,
  input logic                       out_head_valid,
  input logic [rlq_pkg::TCNT_W-1:0] out_total_count,
  input logic [rlq_pkg::STAT_W-1:0] out_status
);

  // A held result beat keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_head_index) &&
      $stable(out_total_count) && $stable(out_status) && $stable(out_head_valid))
    else $error("result beat changed while stalled");

  // Every accepted input beat shows up as a result beat in the cycle after it.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted beat produced no result");

  // The head flag agrees with the entry count.
  a_head_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_head_valid == (out_total_count != '0)))
    else $error("head_valid disagrees with total_count");

  // A pop on an empty queue leaves it empty.
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == rlq_pkg::ST_POP_EMPTY) |->
      !out_head_valid && (out_head_index == '0))
    else $error("pop on empty reported a head");

endmodule

bind four_level_ready_queue_unit rlq_checker u_rlq_checker (.*);

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the four-level ready queue. A clocked driver feeds push and
// pop beats from a backlog that the stimulus process fills. A built-in model
// of the four priority FIFOs predicts the queue view after every accepted
// beat. A clocked monitor checks each returned view field by field against
// the oldest prediction, while both sides idle and stall at random rates.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 10;

  typedef struct {
    rlq_pkg::op_t               op;
    logic [rlq_pkg::PIDX_W-1:0] pidx;
    logic [rlq_pkg::LVL_W-1:0]  lvl;
  } sched_op_t;

  typedef struct {
    logic [rlq_pkg::HEAD_W-1:0] head;
    logic                       hvalid;
    logic [rlq_pkg::TCNT_W-1:0] total;
    rlq_pkg::status_t           status;
  } queue_view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_operation = 1'b0;
  logic [rlq_pkg::PIDX_W-1:0] in_process_index = '0;
  logic [rlq_pkg::LVL_W-1:0]  in_priority_level = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [rlq_pkg::HEAD_W-1:0] out_head_index;
  logic                       out_head_valid;
  logic [rlq_pkg::TCNT_W-1:0] out_total_count;
  logic [rlq_pkg::STAT_W-1:0] out_status;

  sched_op_t   op_backlog[$];
  queue_view_t expected_views[$];

  // model of the priority FIFOs
  rlq_pkg::index_t level_store[rlq_pkg::NUM_LEVELS][rlq_pkg::LEVEL_DEPTH];
  int              level_rd[rlq_pkg::NUM_LEVELS];
  int              level_fill[rlq_pkg::NUM_LEVELS];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int err_count = 0;
  int quiet_cycles = 0;

  four_level_ready_queue_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_process_index  (in_process_index),
    .in_priority_level (in_priority_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_head_index    (out_head_index),
    .out_head_valid    (out_head_valid),
    .out_total_count   (out_total_count),
    .out_status        (out_status)
  );

  always #5 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic int first_busy_level();
    for (int lv = 0; lv < rlq_pkg::NUM_LEVELS; lv++) begin
      if (level_fill[lv] != 0) return lv;
    end
    return rlq_pkg::NUM_LEVELS;
  endfunction

  // Apply one beat to the model and return the view the block must report.
  function automatic queue_view_t apply_sched_op(input sched_op_t it);
    queue_view_t v;
    int lv;
    int top;
    int sum;
    v.status = rlq_pkg::ST_DONE;
    lv = int'(it.lvl);
    if (it.op == rlq_pkg::OP_PUSH) begin
      if (level_fill[lv] >= rlq_pkg::LEVEL_DEPTH) begin
        v.status = rlq_pkg::ST_PUSH_FULL;
      end else begin
        level_store[lv][(level_rd[lv] + level_fill[lv]) % rlq_pkg::LEVEL_DEPTH] =
          rlq_pkg::index_t'(it.pidx);
        level_fill[lv]++;
      end
    end else begin
      top = first_busy_level();
      if (top >= rlq_pkg::NUM_LEVELS) begin
        v.status = rlq_pkg::ST_POP_EMPTY;
      end else begin
        level_rd[top] = (level_rd[top] + 1) % rlq_pkg::LEVEL_DEPTH;
        level_fill[top]--;
      end
    end
    top = first_busy_level();
    if (top < rlq_pkg::NUM_LEVELS) begin
      v.head = rlq_pkg::HEAD_W'(level_store[top][level_rd[top]]);
      v.hvalid = 1'b1;
    end else begin
      v.head = '0;
      v.hvalid = 1'b0;
    end
    sum = level_fill[0] + level_fill[1] + level_fill[2] + level_fill[3];
    v.total = rlq_pkg::TCNT_W'(sum);
    return v;
  endfunction

  // Driver: predict on acceptance, hold a stalled beat, else launch the next.
  always @(posedge clk) begin
    sched_op_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_operation <= 1'b0;
      in_process_index <= '0;
      in_priority_level <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        nxt.op = rlq_pkg::op_t'(in_operation);
        nxt.pidx = in_process_index;
        nxt.lvl = in_priority_level;
        expected_views.push_back(apply_sched_op(nxt));
      end
      if (!(in_valid && in_stall)) begin
        if (op_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          nxt = op_backlog.pop_front();
          in_valid <= 1'b1;
          in_operation <= nxt.op;
          in_process_index <= nxt.pidx;
          in_priority_level <= nxt.lvl;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted view, then pick the next stall.
  always @(posedge clk) begin
    queue_view_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_views.size() == 0) begin
          flag_error($sformatf("result with nothing expected: head=%0d count=%0d",
                               out_head_index, out_total_count));
        end else begin
          want = expected_views.pop_front();
          if (out_head_index !== want.head)
            flag_error($sformatf("head_index %0d, want %0d", out_head_index, want.head));
          if (out_head_valid !== want.hvalid)
            flag_error($sformatf("head_valid %0b, want %0b", out_head_valid, want.hvalid));
          if (out_total_count !== want.total)
            flag_error($sformatf("total_count %0d, want %0d", out_total_count, want.total));
          if (out_status !== want.status)
            flag_error($sformatf("status %0d, want %s", out_status, want.status.name()));
        end
      end
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // Watchdog: count cycles with work outstanding and no beat moving.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (in_valid || op_backlog.size() != 0 || expected_views.size() != 0) begin
        if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end else begin
          quiet_cycles <= quiet_cycles + 1;
        end
      end else begin
        quiet_cycles <= 0;
      end
    end
  end

  task automatic add_op(input rlq_pkg::op_t op, input int pidx, input int lvl);
    sched_op_t it;
    it.op = op;
    it.pidx = rlq_pkg::PIDX_W'(pidx);
    it.lvl = rlq_pkg::LVL_W'(lvl);
    op_backlog.push_back(it);
  endtask

  // Hold off new stimulus until every beat has gone out and come back.
  task automatic wait_drained();
    while (op_backlog.size() != 0 || in_valid || expected_views.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int snd_pct[4];
    int rcv_pct[4];
    int done;
    int seg_len;
    int push_pct;
    int one_level;
    int lvl_pick;
    int pidx;
    snd_pct = '{0, 86, 0, 8};
    rcv_pct = '{0, 0, 86, 8};
    for (int lv = 0; lv < rlq_pkg::NUM_LEVELS; lv++) begin
      level_rd[lv] = 0;
      level_fill[lv] = 0;
      for (int k = 0; k < rlq_pkg::LEVEL_DEPTH; k++) level_store[lv][k] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: pop on empty, fill one level past full, every level, pops
    add_op(rlq_pkg::OP_POP, 8'h3C, 2);
    for (int k = 0; k < rlq_pkg::LEVEL_DEPTH; k++) begin
      pidx = (k == 0) ? 8'h00 :
             (k == rlq_pkg::LEVEL_DEPTH - 1) ? 8'hFF : $urandom_range(0, 255);
      add_op(rlq_pkg::OP_PUSH, pidx, 1);
    end
    add_op(rlq_pkg::OP_PUSH, 8'h77, 1);
    add_op(rlq_pkg::OP_PUSH, 8'h5A, 0);
    add_op(rlq_pkg::OP_PUSH, 8'hA5, 3);
    add_op(rlq_pkg::OP_PUSH, 8'h0F, 2);
    add_op(rlq_pkg::OP_POP, 8'hFF, 3);
    add_op(rlq_pkg::OP_POP, 8'h00, 0);
    wait_drained();

    // random: push-heavy and pop-heavy bursts so the queue swings full and empty
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = snd_pct[ph];
      receiver_stall_pct = rcv_pct[ph];
      done = 0;
      while (done < 170) begin
        seg_len = $urandom_range(8, 40);
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 20;
          default: push_pct = 50;
        endcase
        one_level = ($urandom_range(0, 3) == 0);
        lvl_pick = $urandom_range(0, 3);
        for (int k = 0; k < seg_len; k++) begin
          add_op(($urandom_range(0, 99) < push_pct) ? rlq_pkg::OP_PUSH : rlq_pkg::OP_POP,
                 $urandom_range(0, 255), one_level ? lvl_pick : $urandom_range(0, 3));
        end
        done += seg_len;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_views.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_views.size()));
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rlq_pkg.sv
rtl/rlq_cell.sv
rtl/rlq_level.sv
rtl/four_level_ready_queue_unit.sv
rtl/rlq_checker.sv
tb/sv/tb_top.sv
